// ===== hw/rtl/gql_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glyph quad layout package
// shared types and constants for the text quad layout block
// ----------------------------------------------------------------------------
package gql_pkg;

   localparam int GlyphEntries = 256;
   localparam int SlotW        = $clog2(GlyphEntries);

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_LAYOUT  = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;
   localparam logic [1:0] CMD_IGNORED = 2'd3;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;

   localparam logic [2:0] REG_CHAR_WIDTH  = 3'd0;
   localparam logic [2:0] REG_CHAR_HEIGHT = 3'd1;
   localparam logic [2:0] REG_FONT_SIZE   = 3'd2;
   localparam logic [2:0] REG_TEX_WIDTH   = 3'd3;
   localparam logic [2:0] REG_TEX_HEIGHT  = 3'd4;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        char_code;
      logic [7:0]        glyph_width;
      logic [7:0]        glyph_height;
      logic signed [7:0] glyph_offset_x;
      logic signed [7:0] glyph_offset_y;
      logic [15:0]       glyph_start_u;
      logic [15:0]       glyph_start_v;
      logic [7:0]        color_red;
      logic [7:0]        color_green;
      logic [7:0]        color_blue;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic [7:0]         out_red;
      logic [7:0]         out_green;
      logic [7:0]         out_blue;
      logic [15:0]        quad_number;
      logic [1:0]         corner;
      logic               last_corner;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/gql_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial divider
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gql_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [55:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [55:0]      quotient
);
   logic [55:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;
   logic [17:0] diff;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff[15:0], q_ff[55]};
      diff    = {1'b0, trial} - {2'b00, d_ff};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 6'd56;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[17]) begin
            r_in = diff[16:0];
            q_in = {q_ff[54:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done     = busy_ff && cnt_ff == 6'd1;
   assign quotient = q_in;
endmodule
`default_nettype wire

// ===== hw/rtl/glyph_quad_layout.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glyph quad layout
// lays out text characters as four textured quad vertices each
// ----------------------------------------------------------------------------
// One beat in at a time. Load and start beats leave the block idle, so
// req_ready stays high; newline and space beats pass through the read state
// before req_ready is high again. A glyph beat runs six divisions through one
// shared 56-step serial divider (du, dv, then x and y of the two distinct
// corner positions each); each division has a launch state plus the divider
// steps, and after the read state and the divisions the glyph sends four
// vertex beats on rsp_, each held while rsp_ready is low. Negative positions
// are divided by magnitude and floor-corrected.
module glyph_quad_layout (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire gql_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output gql_pkg::rsp_type     rsp_data,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [2:0]      csr_index,
   input  wire logic [15:0]     csr_data
);
   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   // division jobs, in the order they run
   localparam logic [2:0] JOB_DU = 3'd0;
   localparam logic [2:0] JOB_DV = 3'd1;
   localparam logic [2:0] JOB_X0 = 3'd2;
   localparam logic [2:0] JOB_X1 = 3'd3;
   localparam logic [2:0] JOB_Y0 = 3'd4;
   localparam logic [2:0] JOB_Y1 = 3'd5;

   logic [2:0]  st_ff;
   logic [15:0] cw_ff, ch_ff;
   logic [7:0]  fs_ff;
   logic [12:0] tw_ff, th_ff;
   logic signed [31:0] penx_ff, peny_ff;
   logic [9:0]  lh_ff;
   logic [15:0] qc_ff;
   gql_pkg::req_type cur_ff;

   // glyph table memories
   logic [31:0] met_mem [gql_pkg::GlyphEntries];
   logic [31:0] org_mem [gql_pkg::GlyphEntries];
   logic [31:0] met_rd_ff, org_rd_ff;
   logic [gql_pkg::SlotW-1:0] slot;

   assign slot = req_data.char_code[gql_pkg::SlotW-1:0];

   // entry is read once on the accepted beat and held for the whole glyph
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         if (req_data.command == gql_pkg::CMD_LOAD) begin
            met_mem[slot] <= {req_data.glyph_offset_y, req_data.glyph_offset_x,
                              req_data.glyph_height, req_data.glyph_width};
            org_mem[slot] <= {req_data.glyph_start_v, req_data.glyph_start_u};
         end
         met_rd_ff <= met_mem[slot];
         org_rd_ff <= org_mem[slot];
      end
   end

   assign req_ready = st_ff == ST_IDLE;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_ff <= 16'd256;
         ch_ff <= 16'd256;
         fs_ff <= 8'd16;
         tw_ff <= 13'd256;
         th_ff <= 13'd256;
      end else if (csr_valid) begin
         case (csr_index)
            gql_pkg::REG_CHAR_WIDTH:  cw_ff <= csr_data;
            gql_pkg::REG_CHAR_HEIGHT: ch_ff <= csr_data;
            gql_pkg::REG_FONT_SIZE:   fs_ff <= csr_data[7:0];
            gql_pkg::REG_TEX_WIDTH:   tw_ff <= csr_data[12:0];
            gql_pkg::REG_TEX_HEIGHT:  th_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // glyph fields
   logic [7:0] gw, gh;
   logic signed [7:0] gox, goy;
   assign gw  = met_rd_ff[7:0];
   assign gh  = met_rd_ff[15:8];
   assign gox = met_rd_ff[23:16];
   assign goy = met_rd_ff[31:24];

   logic [2:0]  job_ff;
   logic [16:0] du_ff, dv_ff;
   logic signed [31:0] xs0_ff, xs1_ff, ys0_ff, ys1_ff;
   logic [1:0]  k_ff;

   // positions before scaling, 34-bit signed Q.8
   logic signed [33:0] x0p, x1p, y0p, y1p, posv;
   assign x0p = 34'(penx_ff);
   assign x1p = 34'(penx_ff) + 34'($signed({1'b0, gw, 8'd0}));
   assign y0p = 34'(peny_ff) - 34'($signed({goy, 8'd0}));
   assign y1p = y0p + 34'($signed({1'b0, gh, 8'd0}));

   always_comb begin
      case (job_ff)
         JOB_X0:  posv = x0p;
         JOB_X1:  posv = x1p;
         JOB_Y0:  posv = y0p;
         default: posv = y1p;
      endcase
   end

   logic [33:0] mag;
   logic        neg_ff;
   logic [15:0] size;
   logic [49:0] prod;
   logic [15:0] fsd;
   assign mag  = posv[33] ? 34'(-posv) : 34'(posv);
   assign size = (job_ff == JOB_X0 || job_ff == JOB_X1) ? cw_ff : ch_ff;
   assign prod = 50'(mag) * 50'(size);
   assign fsd  = {(fs_ff == 8'd0) ? 8'd1 : fs_ff, 8'd0};

   logic        div_start;
   logic [55:0] div_num;
   logic [15:0] div_den;
   logic        div_done;
   logic [55:0] div_q;

   always_comb begin
      case (job_ff)
         JOB_DU: begin
            div_num = {32'd0, gw, 16'd0};
            div_den = {3'd0, (tw_ff == 13'd0) ? 13'd1 : tw_ff};
         end
         JOB_DV: begin
            div_num = {32'd0, gh, 16'd0};
            div_den = {3'd0, (th_ff == 13'd0) ? 13'd1 : th_ff};
         end
         default: begin
            // remainder-aware floor: add divisor-1 for negatives
            div_num = posv[33] ? 56'(prod) + 56'(fsd) - 56'd1 : 56'(prod);
            div_den = fsd;
         end
      endcase
   end

   gql_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_num), .divisor(div_den),
      .done(div_done), .quotient(div_q)
   );

   // signed, saturated scaled value
   logic signed [57:0] sq;
   logic signed [31:0] sat;
   assign sq  = neg_ff ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
   assign sat = (sq > 58'sd2147483647) ? 32'sh7fffffff :
                (sq < -58'sd2147483648) ? 32'sh80000000 : sq[31:0];

   logic [16:0] dsat;
   assign dsat = (div_q > 56'd131071) ? 17'h1ffff : div_q[16:0];

   assign div_start = st_ff == ST_DIV;

   // pen saturation helpers
   logic signed [33:0] nl_y, sp_x, adv_x;
   assign nl_y  = 34'(peny_ff) - 34'($signed({1'b0, lh_ff})) * 34'sd384;
   assign sp_x  = 34'(penx_ff) + 34'($signed({1'b0, fs_ff, 7'd0}));
   assign adv_x = 34'(penx_ff) + 34'($signed({gox[7], gox, 8'd0}))
                  + 34'($signed({1'b0, gw, 8'd0}));

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7fffffff;
      else if (v < -34'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction

   logic signed [9:0] hoy;
   assign hoy = 10'($signed({1'b0, gh})) + 10'(goy);

   // texcoord sums
   logic [16:0] u0, u1, v0, v1;
   logic [17:0] us, vs;
   assign us = {2'b00, org_rd_ff[15:0]} + {1'b0, du_ff};
   assign vs = {2'b00, org_rd_ff[31:16]} + {1'b0, dv_ff};
   assign u0 = {1'b0, org_rd_ff[15:0]};
   assign v0 = {1'b0, org_rd_ff[31:16]};
   assign u1 = us[17] ? 17'h1ffff : us[16:0];
   assign v1 = vs[17] ? 17'h1ffff : vs[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         penx_ff <= '0;
         peny_ff <= '0;
         lh_ff   <= '0;
         qc_ff   <= '0;
         job_ff  <= '0;
         k_ff    <= '0;
      end else begin
         case (st_ff)
            ST_IDLE: if (req_valid) begin
               cur_ff <= req_data;
               if (req_data.command == gql_pkg::CMD_LAYOUT) st_ff <= ST_READ;
               else if (req_data.command == gql_pkg::CMD_START) begin
                  penx_ff <= '0;
                  peny_ff <= '0;
                  lh_ff   <= '0;
                  qc_ff   <= '0;
               end
            end
            ST_READ: begin
               if (cur_ff.char_code == gql_pkg::CHAR_NEWLINE) begin
                  peny_ff <= sat34(nl_y);
                  penx_ff <= '0;
                  st_ff   <= ST_IDLE;
               end else if (cur_ff.char_code == gql_pkg::CHAR_SPACE) begin
                  penx_ff <= sat34(sp_x);
                  st_ff   <= ST_IDLE;
               end else begin
                  job_ff <= JOB_DU;
                  st_ff  <= ST_DIV;
               end
            end
            ST_DIV: begin
               neg_ff <= posv[33] && job_ff >= JOB_X0;
               st_ff  <= ST_WAIT;
            end
            ST_WAIT: if (div_done) begin
               case (job_ff)
                  JOB_DU: du_ff  <= dsat;
                  JOB_DV: dv_ff  <= dsat;
                  JOB_X0: xs0_ff <= sat;
                  JOB_X1: xs1_ff <= sat;
                  JOB_Y0: ys0_ff <= sat;
                  default: ys1_ff <= sat;
               endcase
               if (job_ff == JOB_Y1) begin
                  k_ff  <= '0;
                  st_ff <= ST_EMIT;
                  if (hoy > $signed({1'b0, lh_ff})) lh_ff <= hoy;
               end else begin
                  job_ff <= job_ff + 3'd1;
                  st_ff  <= ST_DIV;
               end
            end
            ST_EMIT: if (rsp_ready) begin
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  penx_ff <= sat34(adv_x);
                  qc_ff   <= qc_ff + 16'd1;
                  st_ff   <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = st_ff == ST_EMIT;
   always_comb begin
      rsp_data.vertex_x    = (k_ff == 2'd1 || k_ff == 2'd2) ? xs1_ff : xs0_ff;
      rsp_data.vertex_y    = k_ff[1] ? ys1_ff : ys0_ff;
      rsp_data.tex_u       = (k_ff == 2'd1 || k_ff == 2'd2) ? u1 : u0;
      rsp_data.tex_v       = k_ff[1] ? v0 : v1;
      rsp_data.out_red     = cur_ff.color_red;
      rsp_data.out_green   = cur_ff.color_green;
      rsp_data.out_blue    = cur_ff.color_blue;
      rsp_data.quad_number = qc_ff;
      rsp_data.corner      = k_ff;
      rsp_data.last_corner = k_ff == 2'd3;
   end
endmodule
`default_nettype wire

// ===== bench/glyph_quad_layout_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph quad layout testbench
// drives load, start and layout beats with random gaps on both channels,
// predicts every vertex beat in a scoreboard and compares field by field
// ----------------------------------------------------------------------------

// keeps its own copy of pen, line height, quad count and glyph table
class glyph_vertex_scoreboard;
   int unsigned   char_w, char_h, font_px, atlas_w, atlas_h;
   longint        pen_x, pen_y;
   int            line_px;
   logic [15:0]   quad_idx;
   logic [7:0]    gw [256];
   logic [7:0]    gh [256];
   logic signed [7:0] gox [256];
   logic signed [7:0] goy [256];
   logic [15:0]   gu [256];
   logic [15:0]   gv [256];
   gql_pkg::rsp_type vertex_q[$];
   int            errors;

   function new();
      char_w = 256; char_h = 256; font_px = 16; atlas_w = 256; atlas_h = 256;
      pen_x = 0; pen_y = 0; line_px = 0; quad_idx = 0; errors = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
         gql_pkg::REG_CHAR_WIDTH:  char_w  = 32'(val);
         gql_pkg::REG_CHAR_HEIGHT: char_h  = 32'(val);
         gql_pkg::REG_FONT_SIZE:   font_px = 32'(val[7:0]);
         gql_pkg::REG_TEX_WIDTH:   atlas_w = 32'(val[12:0]);
         gql_pkg::REG_TEX_HEIGHT:  atlas_h = 32'(val[12:0]);
         default: ;
      endcase
   endfunction

   function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint scale_pos(longint pos, int unsigned size);
      longint n, d, q;
      n = pos * longint'(size);
      d = (font_px == 0 ? 1 : font_px) * 256;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return sat32(q);
   endfunction

   function longint sat_tex(longint v);
      return v > 131071 ? 131071 : v;
   endfunction

   function void note_request(gql_pkg::req_type r);
      longint w, h, ox, oy, du, dv, xs[4], ys[4], us[4], vs[4];
      gql_pkg::rsp_type e;
      int s;
      s = int'(r.char_code);
      case (r.command)
         gql_pkg::CMD_LOAD: begin
            gw[s] = r.glyph_width; gh[s] = r.glyph_height;
            gox[s] = r.glyph_offset_x; goy[s] = r.glyph_offset_y;
            gu[s] = r.glyph_start_u; gv[s] = r.glyph_start_v;
         end
         gql_pkg::CMD_START: begin
            pen_x = 0; pen_y = 0; line_px = 0; quad_idx = 0;
         end
         gql_pkg::CMD_LAYOUT: begin
            if (r.char_code == gql_pkg::CHAR_NEWLINE) begin
               pen_y = sat32(pen_y - longint'(line_px) * 384);
               pen_x = 0;
            end else if (r.char_code == gql_pkg::CHAR_SPACE) begin
               pen_x = sat32(pen_x + longint'(font_px) * 128);
            end else begin
               w = gw[s]; h = gh[s]; ox = gox[s]; oy = goy[s];
               du = (w << 16) / (atlas_w == 0 ? 1 : atlas_w);
               dv = (h << 16) / (atlas_h == 0 ? 1 : atlas_h);
               xs[0] = pen_x;        xs[3] = pen_x;
               xs[1] = pen_x + w * 256; xs[2] = xs[1];
               ys[0] = pen_y - oy * 256; ys[1] = ys[0];
               ys[2] = ys[0] + h * 256;  ys[3] = ys[2];
               us[0] = gu[s]; us[3] = gu[s]; us[1] = gu[s] + du; us[2] = us[1];
               vs[2] = gv[s]; vs[3] = gv[s]; vs[0] = gv[s] + dv; vs[1] = vs[0];
               if (h + oy > line_px) line_px = int'((h + oy) & 10'h3ff);
               for (int k = 0; k < 4; k++) begin
                  e.vertex_x    = 32'(scale_pos(xs[k], char_w));
                  e.vertex_y    = 32'(scale_pos(ys[k], char_h));
                  e.tex_u       = 17'(sat_tex(us[k]));
                  e.tex_v       = 17'(sat_tex(vs[k]));
                  e.out_red     = r.color_red;
                  e.out_green   = r.color_green;
                  e.out_blue    = r.color_blue;
                  e.quad_number = quad_idx;
                  e.corner      = 2'(k);
                  e.last_corner = (k == 3);
                  vertex_q = {vertex_q, e};
               end
               pen_x = sat32(pen_x + (w + ox) * 256);
               quad_idx++;
            end
         end
         default: ;
      endcase
   endfunction

   task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task check_vertex(gql_pkg::rsp_type got);
      gql_pkg::rsp_type e;
      if (vertex_q.size() == 0) begin
         report("unexpected vertex beat, corner", got.corner, -1);
         return;
      end
      e = vertex_q.pop_front();
      if (got.vertex_x !== e.vertex_x) report("vertex_x", got.vertex_x, e.vertex_x);
      if (got.vertex_y !== e.vertex_y) report("vertex_y", got.vertex_y, e.vertex_y);
      if (got.tex_u !== e.tex_u) report("tex_u", got.tex_u, e.tex_u);
      if (got.tex_v !== e.tex_v) report("tex_v", got.tex_v, e.tex_v);
      if (got.out_red !== e.out_red) report("out_red", got.out_red, e.out_red);
      if (got.out_green !== e.out_green) report("out_green", got.out_green, e.out_green);
      if (got.out_blue !== e.out_blue) report("out_blue", got.out_blue, e.out_blue);
      if (got.quad_number !== e.quad_number)
         report("quad_number", got.quad_number, e.quad_number);
      if (got.corner !== e.corner) report("corner", got.corner, e.corner);
      if (got.last_corner !== e.last_corner)
         report("last_corner", got.last_corner, e.last_corner);
   endtask
endclass

module glyph_quad_layout_tb;

   // no-acceptance limit: covers the receiver hold-off and glyph processing
   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 400;
   localparam int SettleCycles = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   gql_pkg::req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   gql_pkg::rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   glyph_vertex_scoreboard sb = new();

   bit     glyph_loaded [256];
   bit     calm;            // no idling on either side while set
   int     hold_reqs = 0;   // long receiver stalls asked for so far
   int     idle_cycles = 0;

   always #4 clock = ~clock;

   glyph_quad_layout dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 50) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   // watchdog: cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random back-pressure, plus the long hold-off when asked
   initial begin
      int stall_left;
      int holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_vertex(rsp_data);
         if (hold_reqs != holds_done) begin
            rsp_ready <= 1'b0;
            repeat (700) @(posedge clock);
            holds_done++;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
         end
      end
   end

   // one request beat; valid stays up into the next beat when there is no gap
   task automatic send_beat(gql_pkg::req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sb.note_request(r);
      if (r.command == gql_pkg::CMD_LOAD) glyph_loaded[r.char_code] = 1'b1;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.vertex_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // valid is left high so writes can follow back to back
   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.set_reg(idx, val);
   endtask

   task automatic set_all(logic [15:0] cw, logic [15:0] ch, logic [15:0] fs,
                          logic [15:0] tw, logic [15:0] th);
      quiesce();
      write_reg(gql_pkg::REG_CHAR_WIDTH, cw);
      write_reg(gql_pkg::REG_CHAR_HEIGHT, ch);
      write_reg(gql_pkg::REG_FONT_SIZE, fs);
      write_reg(gql_pkg::REG_TEX_WIDTH, tw);
      write_reg(gql_pkg::REG_TEX_HEIGHT, th);
      csr_valid <= 1'b0;
   endtask

   function automatic gql_pkg::req_type load_beat(logic [7:0] code, logic [7:0] w,
                                                  logic [7:0] h, logic [7:0] ox,
                                                  logic [7:0] oy,
                                                  logic [15:0] u, logic [15:0] v);
      gql_pkg::req_type r;
      r = '0;
      r.command = gql_pkg::CMD_LOAD; r.char_code = code;
      r.glyph_width = w; r.glyph_height = h;
      r.glyph_offset_x = ox; r.glyph_offset_y = oy;
      r.glyph_start_u = u; r.glyph_start_v = v;
      return r;
   endfunction

   function automatic gql_pkg::req_type char_beat(logic [1:0] cmd, logic [7:0] code,
                                                  logic [23:0] rgb);
      gql_pkg::req_type r;
      r = '0;
      r.command = cmd; r.char_code = code;
      {r.color_red, r.color_green, r.color_blue} = rgb;
      return r;
   endfunction

   // random beat: mostly glyphs of loaded entries, spiced with the rest
   function automatic gql_pkg::req_type random_beat();
      gql_pkg::req_type r;
      logic [127:0] raw;
      int p;
      logic [7:0] code;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(gql_pkg::req_type)-1:0];
      p = $urandom_range(0, 99);
      if (p < 10) begin
         r.command = gql_pkg::CMD_LOAD;
      end else if (p < 16) begin
         r.command = gql_pkg::CMD_START;
      end else if (p < 22) begin
         r.command = gql_pkg::CMD_LAYOUT; r.char_code = gql_pkg::CHAR_NEWLINE;
      end else if (p < 28) begin
         r.command = gql_pkg::CMD_LAYOUT; r.char_code = gql_pkg::CHAR_SPACE;
      end else if (p < 30) begin
         r.command = gql_pkg::CMD_IGNORED;
      end else begin
         r.command = gql_pkg::CMD_LAYOUT;
         do code = 8'($urandom); while (!glyph_loaded[code]);
         r.char_code = code;
      end
      return r;
   endfunction

   task automatic random_phase(int beats, bit with_hold, bit with_pause);
      for (int i = 0; i < beats; i++) begin
         calm = (i >= beats / 3 && i < beats / 3 + 12);
         if (with_hold && i == beats / 2) hold_reqs++;
         if (with_pause && i == beats / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.vertex_q.size() != 0);
         end
         send_beat(random_beat());
      end
      calm = 1'b0;
   endtask

   initial begin
      calm = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, every command and the corner cases
      send_beat(load_beat(8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 16'h0000, 16'h0000));
      send_beat(load_beat(8'd255, 8'd255, 8'd255, 8'sd127, -8'sd128, 16'hffff, 16'hffff));
      send_beat(load_beat(8'd65, 8'd8, 8'd12, -8'sd128, 8'sd127, 16'h1234, 16'hfedc));
      // height plus bearing below zero
      send_beat(load_beat(8'd66, 8'd3, 8'd0, 8'sd1, -8'sd128, 16'h8000, 16'h0001));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd0, 24'h000000));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd255, 24'hffffff));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd66, 24'h55aa55));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, gql_pkg::CHAR_NEWLINE, 24'h0));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd65, 24'haa55aa));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, gql_pkg::CHAR_SPACE, 24'h0));
      send_beat(char_beat(gql_pkg::CMD_IGNORED, 8'd65, 24'h123456));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd255, 24'h0f0f0f));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, gql_pkg::CHAR_NEWLINE, 24'h0));
      send_beat(char_beat(gql_pkg::CMD_START, 8'd0, 24'h0));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd65, 24'hf0f0f0));
      // reload an entry already in use
      send_beat(load_beat(8'd65, 8'd1, 8'd1, 8'sd0, 8'sd0, 16'h0100, 16'h0100));
      send_beat(char_beat(gql_pkg::CMD_LAYOUT, 8'd65, 24'h808080));

      // fill the table with random glyphs for the random part
      for (int i = 0; i < 20; i++) send_beat(load_beat(8'($urandom), 8'($urandom),
         8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)));

      random_phase(80, 1'b1, 1'b0);

      // zero font size and zero atlas width, widest character
      set_all(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h1fff);
      random_phase(70, 1'b0, 1'b1);

      // zero character width and unit atlas sizes against the largest font and height
      set_all(16'h0000, 16'hffff, 16'h00ff, 16'h0001, 16'h0001);
      random_phase(70, 1'b0, 1'b0);

      set_all(16'h0180, 16'h0080, 16'h0001, 16'h1000, 16'h1000);
      random_phase(70, 1'b1, 1'b0);

      set_all(16'($urandom), 16'($urandom), 16'($urandom_range(1, 255)),
              16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
      random_phase(80, 1'b0, 1'b0);

      req_valid <= 1'b0;
      while (sb.vertex_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/gql_pkg.sv
hw/rtl/gql_div.sv
hw/rtl/glyph_quad_layout.sv
bench/glyph_quad_layout_tb.sv
